@@ rtl/core/tis_pkg.sv @@
// ----------------------------------------------------------------------------
// tis_pkg
// Shared types and constants for the tower isolation selector: field widths,
// operation codes, register indexes and the stored tower word.
// ----------------------------------------------------------------------------
`default_nettype none

package tis_pkg;

  localparam int VAL_W     = 16;
  localparam int ETA_IN_W  = 5;
  localparam int PHI_IN_W  = 6;
  localparam int CFG_IDX_W = 3;
  localparam int NUM_REGS  = 6;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_PEAK_TARGET   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PEAK_VERTICAL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PEAK_VETO     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ADC_TARGET    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ADC_VERTICAL  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ADC_VETO      = 3'd5;

  typedef logic signed [VAL_W-1:0]    val_t;
  typedef logic        [ETA_IN_W-1:0] eta_in_t;
  typedef logic        [PHI_IN_W-1:0] phi_in_t;
  typedef logic        [CFG_IDX_W-1:0] cfg_idx_t;

  typedef struct packed {
    val_t peak;
    val_t adc;
    val_t time_val;
  } tower_t;

endpackage

`default_nettype wire

@@ rtl/core/tower_isolation_selector_core.sv @@
// ----------------------------------------------------------------------------
// tower_isolation_selector_core
// Holds a grid of calorimeter towers and tests queried towers for isolation
// on calibrated peak and on raw ADC, reading the neighbourhood one tower at a
// time from a single tower memory.
//
//   Channel   Direction  Handshake            Transaction
//   input     in         in_valid / in_stall  load or query of one tower
//   output    out        out_valid / out_stall one query result
//   config    in         cfg_write            one threshold register write
//
// A load produces no result. An in-range query makes nine reads on the single
// read port of the tower memory, and the sequencer steps through its run,
// wait and finish states. An out-of-range query skips the reads and goes
// from idle straight to finish.
// Reset clears the sequencer and the threshold registers; the memory keeps
// its contents. A stalled result waits in the output register while further
// loads and the work of one further query proceed.
// ----------------------------------------------------------------------------
`default_nettype none

module tower_isolation_selector_core #(
  parameter int ETA_BINS = 24,
  parameter int PHI_BINS = 64
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  output logic                in_stall,
  input  wire                 op,
  input  tis_pkg::eta_in_t    eta_bin,
  input  tis_pkg::phi_in_t    phi_bin,
  input  tis_pkg::val_t       peak_value,
  input  tis_pkg::val_t       adc_value,
  input  tis_pkg::val_t       time_value,
  input  wire                 bad_fit,
  output logic                out_valid,
  input  wire                 out_stall,
  output tis_pkg::eta_in_t    out_eta,
  output tis_pkg::phi_in_t    out_phi,
  output logic                peak_selected,
  output logic                adc_selected,
  output tis_pkg::val_t       out_peak,
  output tis_pkg::val_t       out_adc,
  output tis_pkg::val_t       out_time,
  input  wire                 cfg_write,
  input  tis_pkg::cfg_idx_t   cfg_index,
  input  tis_pkg::val_t       cfg_data
);
  import tis_pkg::*;

  localparam int DEPTH  = ETA_BINS * PHI_BINS;
  localparam int ETA_W  = $clog2(ETA_BINS);
  localparam int PHI_W  = $clog2(PHI_BINS);
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int STEP_W = 4;

  localparam logic [STEP_W-1:0] STEP_CENTRE  = 4'd0;
  localparam logic [STEP_W-1:0] STEP_UP      = 4'd1;
  localparam logic [STEP_W-1:0] STEP_DOWN    = 4'd2;
  localparam logic [STEP_W-1:0] STEP_LO_UP   = 4'd3;
  localparam logic [STEP_W-1:0] STEP_LO_MID  = 4'd4;
  localparam logic [STEP_W-1:0] STEP_LO_DOWN = 4'd5;
  localparam logic [STEP_W-1:0] STEP_HI_UP   = 4'd6;
  localparam logic [STEP_W-1:0] STEP_HI_MID  = 4'd7;
  localparam logic [STEP_W-1:0] STEP_HI_DOWN = 4'd8;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_WAIT,
    ST_FINISH
  } state_t;

  state_t state;

  tower_t grid [DEPTH];
  tower_t rd_word;
  tower_t wr_word;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;
  logic              wr_en;

  val_t cfg_reg [NUM_REGS];

  logic [ETA_W-1:0] in_eta;
  logic [PHI_W-1:0] in_phi;
  logic             in_range;
  logic             accept;

  eta_in_t          q_eta_raw;
  phi_in_t          q_phi_raw;
  logic [ETA_W-1:0] q_eta;
  logic [ETA_W-1:0] q_eta_lo;
  logic [ETA_W-1:0] q_eta_hi;
  logic [PHI_W-1:0] q_phi;
  logic [PHI_W-1:0] q_phi_up;
  logic [PHI_W-1:0] q_phi_down;
  logic             q_has_lo;
  logic             q_has_hi;

  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] rd_tag;
  logic              rd_live;

  logic peak_ok;
  logic adc_ok;
  val_t cur_peak;
  val_t cur_adc;
  val_t cur_time;

  logic [ETA_W-1:0] sel_eta;
  logic [PHI_W-1:0] sel_phi;

  val_t thr_peak;
  val_t thr_adc;
  logic mode_min;
  logic test_on;
  logic pass_peak;
  logic pass_adc;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign in_eta   = ETA_W'(eta_bin);
  assign in_phi   = PHI_W'(phi_bin);
  assign in_range = ({27'd0, eta_bin} < 32'(ETA_BINS)) &&
                    ({26'd0, phi_bin} < 32'(PHI_BINS));

  assign wr_en    = accept && (op == OP_LOAD) && in_range;
  assign wr_addr  = ADDR_W'(32'(in_eta) * PHI_BINS + 32'(in_phi));
  assign wr_word.peak     = bad_fit ? '0 : peak_value;
  assign wr_word.adc      = adc_value;
  assign wr_word.time_val = time_value;

  always_comb begin
    sel_eta = q_eta;
    sel_phi = q_phi;
    case (step)
      STEP_CENTRE: begin
        sel_eta = q_eta;
        sel_phi = q_phi;
      end
      STEP_UP: begin
        sel_eta = q_eta;
        sel_phi = q_phi_up;
      end
      STEP_DOWN: begin
        sel_eta = q_eta;
        sel_phi = q_phi_down;
      end
      STEP_LO_UP: begin
        sel_eta = q_eta_lo;
        sel_phi = q_phi_up;
      end
      STEP_LO_MID: begin
        sel_eta = q_eta_lo;
        sel_phi = q_phi;
      end
      STEP_LO_DOWN: begin
        sel_eta = q_eta_lo;
        sel_phi = q_phi_down;
      end
      STEP_HI_UP: begin
        sel_eta = q_eta_hi;
        sel_phi = q_phi_up;
      end
      STEP_HI_MID: begin
        sel_eta = q_eta_hi;
        sel_phi = q_phi;
      end
      STEP_HI_DOWN: begin
        sel_eta = q_eta_hi;
        sel_phi = q_phi_down;
      end
      default: begin
        sel_eta = q_eta;
        sel_phi = q_phi;
      end
    endcase
  end

  assign rd_addr = ADDR_W'(32'(sel_eta) * PHI_BINS + 32'(sel_phi));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      grid[wr_addr] <= wr_word;
    end
    rd_word <= grid[rd_addr];
  end

  always_comb begin
    thr_peak = cfg_reg[REG_PEAK_TARGET];
    thr_adc  = cfg_reg[REG_ADC_TARGET];
    mode_min = 1'b1;
    test_on  = 1'b1;
    case (rd_tag)
      STEP_CENTRE: begin
        thr_peak = cfg_reg[REG_PEAK_TARGET];
        thr_adc  = cfg_reg[REG_ADC_TARGET];
      end
      STEP_UP, STEP_DOWN: begin
        thr_peak = cfg_reg[REG_PEAK_VERTICAL];
        thr_adc  = cfg_reg[REG_ADC_VERTICAL];
      end
      STEP_LO_UP, STEP_LO_MID, STEP_LO_DOWN: begin
        thr_peak = cfg_reg[REG_PEAK_VETO];
        thr_adc  = cfg_reg[REG_ADC_VETO];
        mode_min = 1'b0;
        test_on  = q_has_lo;
      end
      STEP_HI_UP, STEP_HI_MID, STEP_HI_DOWN: begin
        thr_peak = cfg_reg[REG_PEAK_VETO];
        thr_adc  = cfg_reg[REG_ADC_VETO];
        mode_min = 1'b0;
        test_on  = q_has_hi;
      end
      default: begin
        test_on = 1'b0;
      end
    endcase
    if (mode_min) begin
      pass_peak = $signed(rd_word.peak) >= $signed(thr_peak);
      pass_adc  = $signed(rd_word.adc) >= $signed(thr_adc);
    end else begin
      pass_peak = $signed(rd_word.peak) <= $signed(thr_peak);
      pass_adc  = $signed(rd_word.adc) <= $signed(thr_adc);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        cfg_reg[i] <= '0;
      end
    end else if (cfg_write && (32'(cfg_index) < NUM_REGS)) begin
      cfg_reg[cfg_index] <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= STEP_CENTRE;
      rd_tag    <= STEP_CENTRE;
      rd_live   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      rd_live <= (state == ST_RUN);
      rd_tag  <= step;
      if (out_valid && !out_stall && (state != ST_FINISH)) begin
        out_valid <= 1'b0;
      end
      if (rd_live && test_on) begin
        peak_ok <= peak_ok && pass_peak;
        adc_ok  <= adc_ok && pass_adc;
      end
      if (rd_live && (rd_tag == STEP_CENTRE)) begin
        cur_peak <= rd_word.peak;
        cur_adc  <= rd_word.adc;
        cur_time <= rd_word.time_val;
      end
      case (state)
        ST_IDLE: begin
          if (accept && (op == OP_QUERY)) begin
            q_eta_raw  <= eta_bin;
            q_phi_raw  <= phi_bin;
            q_eta      <= in_eta;
            q_phi      <= in_phi;
            q_phi_up   <= (in_phi == PHI_W'(PHI_BINS - 1)) ? '0 : in_phi + 1'b1;
            q_phi_down <= (in_phi == '0) ? PHI_W'(PHI_BINS - 1) : in_phi - 1'b1;
            q_has_lo   <= (in_eta != '0);
            q_has_hi   <= (in_eta != ETA_W'(ETA_BINS - 1));
            q_eta_lo   <= (in_eta != '0) ? in_eta - 1'b1 : in_eta;
            q_eta_hi   <= (in_eta != ETA_W'(ETA_BINS - 1)) ? in_eta + 1'b1 : in_eta;
            step       <= STEP_CENTRE;
            if (in_range) begin
              peak_ok <= 1'b1;
              adc_ok  <= 1'b1;
              state   <= ST_RUN;
            end else begin
              peak_ok  <= 1'b0;
              adc_ok   <= 1'b0;
              cur_peak <= '0;
              cur_adc  <= '0;
              cur_time <= '0;
              state    <= ST_FINISH;
            end
          end
        end
        ST_RUN: begin
          step <= step + 1'b1;
          if (step == STEP_HI_DOWN) begin
            state <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          state <= ST_FINISH;
        end
        ST_FINISH: begin
          if (!out_valid || !out_stall) begin
            out_valid     <= 1'b1;
            out_eta       <= q_eta_raw;
            out_phi       <= q_phi_raw;
            peak_selected <= peak_ok;
            adc_selected  <= adc_ok;
            out_peak      <= cur_peak;
            out_adc       <= cur_adc;
            out_time      <= cur_time;
            state         <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
